[design/fpc_pkg.sv]
// Package for the fog parameter crossfade unit.
// Holds field widths, action codes, reset values and the control structs.
// Used by fpc_ctrl, fpc_dp and fog_parameter_crossfade_unit.
package fpc_pkg;

  // Default fraction width of the blend factor.
  localparam int unsigned FRACTION_BITS_DEFAULT = 16;

  // Field widths.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned COLOUR_IN_W = 8;
  localparam int unsigned CHAN_W = 16;
  localparam int unsigned DUR_W = 15;
  localparam int unsigned END_W = 33;
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned CH_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 2;

  // Action codes carried in the input tuser.
  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Channel order.
  localparam logic [CH_IDX_W-1:0] CH_DENS = 2'd0;
  localparam logic [CH_IDX_W-1:0] CH_BLUE = 2'd3;

  // Reset values of the target setting: density 0, colour about 0.3.
  localparam logic [CHAN_W-1:0] TGT_DENS_RESET = 16'd0;
  localparam logic [CHAN_W-1:0] TGT_COLOUR_RESET = 16'd19584;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic mul;
    logic acc;
    logic commit;
    logic [CH_IDX_W-1:0] ch;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

[design/fpc_ctrl.sv]
// Controller of the fog parameter crossfade unit.
// Sequences evaluation, the divide steps and the per-channel blend.
// Depends on fpc_pkg for the command and status structs.
module fpc_ctrl #(
  parameter int unsigned FRACTION_BITS = fpc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fpc_pkg::status_t status,
  output fpc_pkg::cmd_t    cmd
);

  localparam int unsigned CNT_W = $clog2(FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [fpc_pkg::CH_IDX_W-1:0] ch;

  // State, divide step counter and channel index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      ch <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          cnt <= '0;
          ch <= fpc_pkg::CH_DENS;
          state <= status.need_div ? ST_DIV : ST_MUL;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRACTION_BITS - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (ch == fpc_pkg::CH_BLUE) begin
            state <= ST_DONE;
          end else begin
            ch <= ch + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    cmd.ch = ch;
    cmd.capture = (state == ST_IDLE) && s_tvalid;
    cmd.eval = (state == ST_EVAL);
    cmd.div_step = (state == ST_DIV);
    cmd.mul = (state == ST_MUL);
    cmd.acc = (state == ST_ACC);
    cmd.commit = (state == ST_DONE) && status.out_free;
  end

endmodule

[design/fpc_dp.sv]
// Datapath of the fog parameter crossfade unit.
// Holds the fog state, the bit-serial divider, the shared blend multiplier
// and the output register. Depends on fpc_pkg.
module fpc_dp #(
  parameter int unsigned FRACTION_BITS = fpc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fpc_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fpc_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [fpc_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                cfg_valid,
  input  logic                                cfg_data,
  input  fpc_pkg::cmd_t                       cmd,
  output fpc_pkg::status_t                    status
);

  localparam int unsigned FW = FRACTION_BITS + 1;
  localparam int unsigned PW = FW + 18;
  localparam int unsigned CW = fpc_pkg::CHAN_W;
  localparam int unsigned DW = fpc_pkg::DUR_W;
  localparam int unsigned EW = fpc_pkg::END_W;

  // Captured item.
  logic act;
  logic [fpc_pkg::TIME_W-1:0] now;
  logic [CW-1:0] new_val [fpc_pkg::NUM_CH];
  logic [DW-1:0] dur;

  // Fog state.
  logic [CW-1:0] tgt [fpc_pkg::NUM_CH];
  logic [CW-1:0] prv [fpc_pkg::NUM_CH];
  logic [DW-1:0] len;
  logic [EW-1:0] fend;
  logic flat;

  // Working registers.
  logic run;
  logic [DW:0] rdiv;
  logic [FW-1:0] fq;
  logic signed [PW-1:0] prod;
  logic [CW-1:0] res [fpc_pkg::NUM_CH];

  // Evaluation terms.
  logic act_set;
  logic set_zero;
  logic run_c;
  logic [EW-1:0] diff;
  logic [DW-1:0] rem_c;
  logic [DW:0] r2;
  logic signed [CW:0] chan_diff;
  logic signed [PW-1:0] acc_sum;

  assign act_set = (act == fpc_pkg::ACT_SET);
  assign set_zero = act_set && (dur == '0);
  assign run_c = (fend > {1'b0, now}) && (len != '0);
  assign diff = fend - {1'b0, now};
  assign rem_c = (diff > EW'(len)) ? len : diff[DW-1:0];
  assign r2 = {rdiv[DW-1:0], 1'b0};

  assign status.need_div = run_c && !set_zero && (rem_c != len);
  assign status.out_free = !m_tvalid || m_tready;

  // Blend: target * ONE + f * (previous - target), rounded half up.
  assign chan_diff = $signed({1'b0, prv[cmd.ch]}) - $signed({1'b0, tgt[cmd.ch]});
  assign acc_sum = $signed({3'b000, tgt[cmd.ch], {FRACTION_BITS{1'b0}}}) + prod
                   + $signed(PW'(1) << (FRACTION_BITS - 1));

  // Flat shading register.
  always_ff @(posedge clk) begin
    if (rst) begin
      flat <= 1'b0;
    end else if (cfg_valid) begin
      flat <= cfg_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= s_tuser;
      now <= s_tdata[31:0];
      new_val[0] <= {s_tdata[39:32], 8'd0};
      new_val[1] <= {s_tdata[47:40], 8'd0};
      new_val[2] <= {s_tdata[55:48], 8'd0};
      new_val[3] <= {s_tdata[63:56], 8'd0};
      dur <= s_tdata[78:64];
    end
  end

  // Fog state: loaded at evaluation for an immediate switch, at commit
  // for a faded set.
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt[0] <= fpc_pkg::TGT_DENS_RESET;
      tgt[1] <= fpc_pkg::TGT_COLOUR_RESET;
      tgt[2] <= fpc_pkg::TGT_COLOUR_RESET;
      tgt[3] <= fpc_pkg::TGT_COLOUR_RESET;
      for (int i = 0; i < fpc_pkg::NUM_CH; i++) begin
        prv[i] <= '0;
      end
      len <= '0;
      fend <= '0;
    end else if (cmd.eval && set_zero) begin
      for (int i = 0; i < fpc_pkg::NUM_CH; i++) begin
        tgt[i] <= new_val[i];
      end
      len <= '0;
      fend <= {1'b0, now};
    end else if (cmd.commit && act_set && (dur != '0)) begin
      for (int i = 0; i < fpc_pkg::NUM_CH; i++) begin
        tgt[i] <= new_val[i];
        prv[i] <= res[i];
      end
      len <= dur;
      fend <= {1'b0, now} + EW'(dur);
    end
  end

  // Blend factor: preset at evaluation, then one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      run <= run_c && !set_zero;
      rdiv <= {1'b0, rem_c};
      if (run_c && !set_zero && (rem_c == len)) begin
        fq <= {1'b1, {FRACTION_BITS{1'b0}}};
      end else begin
        fq <= '0;
      end
    end else if (cmd.div_step) begin
      if (r2 >= {1'b0, len}) begin
        rdiv <= r2 - {1'b0, len};
        fq <= {fq[FW-2:0], 1'b1};
      end else begin
        rdiv <= r2;
        fq <= {fq[FW-2:0], 1'b0};
      end
    end
  end

  // Shared multiplier and accumulate, one channel at a time.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'($signed({1'b0, fq}) * chan_diff);
    end
    if (cmd.acc) begin
      res[cmd.ch] <= acc_sum[FRACTION_BITS +: CW];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {res[3], res[2], res[1], res[0]};
      m_tuser[0] <= (res[0] != '0) && !flat;
      m_tuser[1] <= (act_set && (dur != '0)) || run;
    end
  end

endmodule

[design/fog_parameter_crossfade_unit.sv]
// Fog parameter crossfade unit: linear fade between two fog settings.
// The result is presented once the input item is accepted and evaluated, and, when a divide is
// needed, run through the one-bit-per-cycle divider; then the shared blend multiplier takes the
// four channels in turn before the result is committed to the output register.
// A new item is taken only once the previous result has been committed, which waits for the
// output to be free. Reset is synchronous, active high; no item is taken during reset.
module fog_parameter_crossfade_unit #(
  parameter int unsigned FRACTION_BITS = fpc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: current_time, new_density, new_red, new_green, new_blue,
  // fade_duration, one zero pad bit.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fpc_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: action.
  input  logic                           s_tuser,
  // m_tdata: density_out, red_out, green_out, blue_out.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fpc_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: fog_on, fading.
  output logic [fpc_pkg::OUT_USER_W-1:0] m_tuser,
  // cfg_data: flat_shading.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  fpc_pkg::cmd_t cmd;
  fpc_pkg::status_t status;
  logic ctrl_ready;

  // The flat shading register is writable whenever the unit is out of reset.
  assign cfg_ready = !rst;

  // Items are taken only out of reset.
  assign s_tready = ctrl_ready && !rst;

  fpc_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(ctrl_ready),
    .status(status),
    .cmd(cmd)
  );

  fpc_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .status(status)
  );

endmodule
